// ===== design/nq_pkg.sv =====
`default_nettype none

package nq_pkg;

  localparam int MaxBoard = 32;
  localparam int BoardW   = 6;
  localparam int MaskW    = 32;
  localparam int CountW   = 64;
  localparam int DepthW   = $clog2(MaxBoard) + 1;
  localparam int AddrW    = $clog2(MaxBoard);

  localparam logic [BoardW-1:0] BoardSizeReset = 6'd8;
  localparam logic [MaskW-1:0]  FullMask       = 32'hFFFF_FFFF;

  // One search frame: squares still to try, and the three attack masks.
  typedef struct packed {
    logic [MaskW-1:0] free;
    logic [MaskW-1:0] cols;
    logic [MaskW-1:0] left;
    logic [MaskW-1:0] right;
  } frame_t;

  // What the placement unit hands back for the current frame.
  typedef struct packed {
    logic [MaskW-1:0] parent_free;
    frame_t           child;
  } step_t;

  function automatic logic [MaskW-1:0] board_mask(input logic [BoardW-1:0] n);
    logic [MaskW:0] one_hot;
    logic [MaskW:0] ones;
    one_hot = (MaskW+1)'(1) << n;
    ones    = one_hot - (MaskW+1)'(1);
    if (n >= BoardW'(MaskW)) begin
      return FullMask;
    end
    return ones[MaskW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/nq_if.sv =====
`default_nettype none

interface nq_cfg_if import nq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BoardW-1:0] board_size;

  modport source (output valid, output board_size, input ready);
  modport sink (input valid, input board_size, output ready);
endinterface

interface nq_in_if import nq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BoardW-1:0] start_row;
  logic [MaskW-1:0]  occupied_columns;
  logic [MaskW-1:0]  left_diagonals;
  logic [MaskW-1:0]  right_diagonals;

  modport source (output valid, output start_row, output occupied_columns,
                  output left_diagonals, output right_diagonals, input ready);
  modport sink (input valid, input start_row, input occupied_columns,
                input left_diagonals, input right_diagonals, output ready);
endinterface

interface nq_out_if import nq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] solution_count;
  logic              bad_start;

  modport source (output valid, output solution_count, output bad_start, input ready);
  modport sink (input valid, input solution_count, input bad_start, output ready);
endinterface

`default_nettype wire

// ===== design/nq_step.sv =====
`default_nettype none

// Placement unit: takes the lowest free square of the current frame and
// builds the frame one row further down.
module nq_step import nq_pkg::*; (
  input  frame_t           cur_i,
  input  logic [MaskW-1:0] brd_i,
  output step_t            step_o
);

  logic [MaskW-1:0] lowest;
  logic [MaskW-1:0] nc;
  logic [MaskW-1:0] nl;
  logic [MaskW-1:0] nr;

  assign lowest = cur_i.free & (~cur_i.free + MaskW'(1));
  assign nc     = cur_i.cols | lowest;
  assign nl     = (cur_i.left | lowest) << 1;
  assign nr     = (cur_i.right | lowest) >> 1;

  assign step_o.parent_free = cur_i.free ^ lowest;
  assign step_o.child.free  = brd_i & ~(nc | nl | nr);
  assign step_o.child.cols  = nc;
  assign step_o.child.left  = nl;
  assign step_o.child.right = nr;

endmodule

`default_nettype wire

// ===== design/n_queens_solution_counter_unit.sv =====
`default_nettype none

// Channel   | Dir | Payload
// cfg_i     | in  | board_size (6 bits), written whenever valid is high
// item_i    | in  | start_row, occupied_columns, left_diagonals, right_diagonals
// result_o  | out | solution_count (64 bits, saturating), bad_start
//
// An item is accepted, then each square is tried in turn; an exhausted frame is
// dropped, and when that frame is not the first one the registered stack read
// follows in ST_POP. Last, ST_FIN moves the count to the output register.
// A start row at or past the board size goes from acceptance straight to ST_FIN.
// Reset sets the board size to 8; the frame stack is not cleared.
// A result waits in the output register; a later item finishes only once it is taken.
module n_queens_solution_counter_unit import nq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nq_cfg_if.sink    cfg_i,
  nq_in_if.sink     item_i,
  nq_out_if.source  result_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [BoardW-1:0] board_size_q;
  logic [BoardW-1:0] start_q, start_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [CountW-1:0] count_q, count_d;
  logic              bad_q, bad_d;
  frame_t            cur_q, cur_d;
  frame_t            rd_q;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              out_bad_q, out_bad_d;

  logic [BoardW-1:0] n;
  logic [MaskW-1:0]  brd;
  step_t             step;
  logic [DepthW-1:0] depth_m1;
  logic [DepthW-1:0] depth_m2;
  logic [BoardW:0]   child_row;
  logic              mem_we;
  logic              mem_re;
  frame_t            mem_wdata;

  frame_t stack_mem [MaxBoard];

  assign n   = (board_size_q > BoardW'(MaxBoard)) ? BoardW'(MaxBoard) : board_size_q;
  assign brd = board_mask(n);

  assign depth_m1  = depth_q - DepthW'(1);
  assign depth_m2  = depth_q - DepthW'(2);
  assign child_row = {1'b0, start_q} + (BoardW+1)'(depth_q);

  nq_step u_step (
    .cur_i  (cur_q),
    .brd_i  (brd),
    .step_o (step)
  );

  assign cfg_i.ready             = 1'b1;
  assign item_i.ready            = (state_q == ST_IDLE);
  assign result_o.valid          = out_valid_q;
  assign result_o.solution_count = out_count_q;
  assign result_o.bad_start      = out_bad_q;

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    depth_d     = depth_q;
    count_d     = count_q;
    bad_d       = bad_q;
    cur_d       = cur_q;
    out_count_d = out_count_q;
    out_bad_d   = out_bad_q;
    out_valid_d = out_valid_q & ~result_o.ready;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = cur_q;
    mem_wdata.free = step.parent_free;

    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          start_d = item_i.start_row;
          depth_d = '0;
          count_d = '0;
          bad_d   = 1'b0;
          if (item_i.start_row > n) begin
            bad_d   = 1'b1;
            state_d = ST_FIN;
          end else if (item_i.start_row == n) begin
            count_d = CountW'(1);
            state_d = ST_FIN;
          end else begin
            cur_d.cols  = item_i.occupied_columns;
            cur_d.left  = item_i.left_diagonals;
            cur_d.right = item_i.right_diagonals;
            cur_d.free  = brd & ~(item_i.occupied_columns | item_i.left_diagonals |
                                  item_i.right_diagonals);
            depth_d     = DepthW'(1);
            state_d     = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (cur_q.free == '0) begin
          depth_d = depth_m1;
          if (depth_q == DepthW'(1)) begin
            state_d = ST_FIN;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_POP;
          end
        end else if (child_row >= {1'b0, n}) begin
          // The square completes the board: count it and try the next one.
          cur_d.free = step.parent_free;
          if (count_q != '1) begin
            count_d = count_q + CountW'(1);
          end
        end else begin
          mem_we  = 1'b1;
          cur_d   = step.child;
          depth_d = depth_q + DepthW'(1);
        end
      end
      ST_POP: begin
        cur_d   = rd_q;
        state_d = ST_RUN;
      end
      ST_FIN: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_count_d = count_q;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      board_size_q <= BoardSizeReset;
      depth_q      <= '0;
      count_q      <= '0;
      bad_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        board_size_q <= cfg_i.board_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    cur_q       <= cur_d;
    out_count_q <= out_count_d;
    out_bad_q   <= out_bad_d;
  end

  // Frame stack: the top frame lives in cur_q, the ones beneath it here.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[depth_m1[AddrW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= stack_mem[depth_m2[AddrW-1:0]];
    end
  end

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (depth_q != '0 && depth_q <= DepthW'(MaxBoard)))
    else $error("search depth out of range while running");

  a_pop_resumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (state_q == ST_RUN))
    else $error("stack read not followed by search");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> (count_q >= $past(count_q)))
    else $error("running count went down during a search");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_count_q == '0))
    else $error("bad start result carries a nonzero count");

endmodule

`default_nettype wire

// ===== sim/tb_n_queens_solution_counter_unit.sv =====
`timescale 1ns / 1ps

module tb_n_queens_solution_counter_unit;
  import nq_pkg::*;

  localparam int unsigned EffortCap = 2000;

  typedef struct {
    logic [BoardW-1:0] start_row;
    logic [MaskW-1:0]  occupied;
    logic [MaskW-1:0]  left_diag;
    logic [MaskW-1:0]  right_diag;
  } placement_t;

  typedef struct {
    logic [CountW-1:0] solutions;
    logic              bad_start;
  } tally_t;

  // Keeps its own copy of the board size and the counts still owed by the block.
  class completion_tally;
    logic [BoardW-1:0] board_size;
    tally_t            pending_counts[$];
    int                errors;

    function new();
      board_size = BoardSizeReset;
      errors = 0;
    endfunction

    function void set_board(logic [BoardW-1:0] value);
      board_size = value;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Depth-first search over explicit frames. Returns 0 as soon as the search
    // takes more than effort_cap steps; a cap of zero means no limit.
    function bit count_completions(placement_t pl, int unsigned effort_cap,
                                   output tally_t res);
      logic [MaskW-1:0]  free_stk[MaxBoard];
      logic [MaskW-1:0]  cols_stk[MaxBoard];
      logic [MaskW-1:0]  left_stk[MaxBoard];
      logic [MaskW-1:0]  right_stk[MaxBoard];
      logic [BoardW-1:0] n;
      logic [MaskW-1:0]  brd, avail, p, nc, nl, nr;
      int unsigned       depth, top, effort;
      res.solutions = '0;
      res.bad_start = 1'b0;
      n = (board_size > BoardW'(MaxBoard)) ? BoardW'(MaxBoard) : board_size;
      brd = (n >= BoardW'(MaskW)) ? FullMask : ((MaskW'(1) << n) - MaskW'(1));
      if (pl.start_row > n) begin
        res.bad_start = 1'b1;
        return 1'b1;
      end
      depth = 0;
      if (pl.start_row == n) begin
        res.solutions = CountW'(1);
      end else begin
        free_stk[0] = brd & ~(pl.occupied | pl.left_diag | pl.right_diag);
        cols_stk[0] = pl.occupied;
        left_stk[0] = pl.left_diag;
        right_stk[0] = pl.right_diag;
        depth = 1;
      end
      effort = 0;
      while (depth > 0) begin
        effort++;
        if (effort_cap != 0 && effort > effort_cap) begin
          return 1'b0;
        end
        top = (depth - 1) % MaxBoard;
        avail = free_stk[top];
        if (avail == '0) begin
          depth--;
          continue;
        end
        p = avail & (~avail + MaskW'(1));
        free_stk[top] = avail ^ p;
        nc = cols_stk[top] | p;
        nl = (left_stk[top] | p) << 1;
        nr = (right_stk[top] | p) >> 1;
        if (int'(pl.start_row) + depth >= int'(n)) begin
          if (res.solutions != '1) begin
            res.solutions++;
          end
        end else begin
          free_stk[depth % MaxBoard] = brd & ~(nc | nl | nr);
          cols_stk[depth % MaxBoard] = nc;
          left_stk[depth % MaxBoard] = nl;
          right_stk[depth % MaxBoard] = nr;
          depth++;
        end
      end
      return 1'b1;
    endfunction

    function void note_item(placement_t pl);
      tally_t t;
      void'(count_completions(pl, 0, t));
      pending_counts.push_back(t);
    endfunction

    task check_result(logic [CountW-1:0] solutions, logic bad_start);
      tally_t t;
      if (pending_counts.size() == 0) begin
        report($sformatf("result count=%0d bad_start=%0b with nothing expected",
                         solutions, bad_start));
        return;
      end
      t = pending_counts.pop_front();
      if (solutions !== t.solutions) begin
        report($sformatf("solution_count got %0d, expected %0d", solutions, t.solutions));
      end
      if (bad_start !== t.bad_start) begin
        report($sformatf("bad_start got %0b, expected %0b", bad_start, t.bad_start));
      end
    endtask

    task close_out();
      if (pending_counts.size() != 0) begin
        report($sformatf("%0d results never arrived", pending_counts.size()));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;

  completion_tally tally;

  nq_cfg_if cfg_if ();
  nq_in_if  item_if ();
  nq_out_if result_if ();

  n_queens_solution_counter_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result side: random stall bursts unless the calm stretch has begun.
  initial begin
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_if.ready = 1'b0;
      end else begin
        result_if.ready = 1'b1;
      end
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      tally.check_result(result_if.solution_count, result_if.bad_start);
    end
  end

  task automatic drain();
    item_if.valid = 1'b0;
    while (tally.pending_counts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_board(input logic [BoardW-1:0] value);
    drain();
    cfg_if.board_size = value;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    tally.set_board(value);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(input placement_t pl);
    if (!calm && $urandom_range(0, 2) == 0) begin
      item_if.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    item_if.start_row = pl.start_row;
    item_if.occupied_columns = pl.occupied;
    item_if.left_diagonals = pl.left_diag;
    item_if.right_diagonals = pl.right_diag;
    item_if.valid = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    tally.note_item(pl);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input int start, input logic [MaskW-1:0] cols,
                             input logic [MaskW-1:0] left, input logic [MaskW-1:0] right);
    placement_t pl;
    pl.start_row = BoardW'(start);
    pl.occupied = cols;
    pl.left_diag = left;
    pl.right_diag = right;
    send_item(pl);
  endtask

  function automatic logic [MaskW-1:0] rand_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FullMask;
      2: return $urandom() & $urandom() & $urandom();
      3: return $urandom() & $urandom();
      4: return $urandom() | $urandom();
      5: return $urandom() | $urandom() | $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Mostly sound partial placements whose remaining search is cheap enough; about one in
  // ten asks for a start row past the board when the board is narrower than MaxBoard.
  task automatic random_phase(input int count, input logic [BoardW-1:0] board);
    placement_t pl;
    tally_t     scratch;
    int         n, k, tries;
    write_board(board);
    n = (board > BoardW'(MaxBoard)) ? MaxBoard : int'(board);
    for (int i = 0; i < count; i++) begin
      tries = 0;
      do begin
        pl.occupied = rand_mask();
        pl.left_diag = rand_mask();
        pl.right_diag = rand_mask();
        if ($urandom_range(0, 9) == 0) begin
          pl.start_row = (n < MaxBoard) ? BoardW'($urandom_range(n + 1, MaxBoard))
                                        : BoardW'($urandom_range(0, MaxBoard));
        end else begin
          k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n)
                                          : $urandom_range(0, (n < 4) ? n : 4);
          if (tries > 8) begin
            k = 0;
          end
          pl.start_row = BoardW'(n - k);
        end
        tries++;
      end while (!tally.count_completions(pl, EffortCap, scratch));
      send_item(pl);
      if (!calm && $urandom_range(0, 24) == 0) begin
        drain();
      end
    end
  endtask

  initial begin
    tally = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.board_size = '0;
    item_if.valid = 1'b0;
    item_if.start_row = '0;
    item_if.occupied_columns = '0;
    item_if.left_diagonals = '0;
    item_if.right_diagonals = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Board size still at its reset value of eight.
    send_fields(0, '0, '0, '0);
    send_fields(8, FullMask, FullMask, FullMask);
    send_fields(9, '0, '0, '0);
    send_fields(32, '0, '0, '0);
    send_fields(7, '0, '0, '0);
    // Column bits above the board must not block anything.
    send_fields(6, 32'hFFFF_FF00, 32'h8000_0000, 32'h0000_0100);
    send_fields(5, 32'hF0F0_F0F0, 32'hAAAA_AAAA, 32'h5555_5555);

    write_board('0);
    send_fields(0, '0, '0, '0);
    send_fields(1, '0, '0, '0);
    send_fields(0, FullMask, FullMask, FullMask);

    write_board(BoardW'(MaxBoard));
    send_fields(32, '0, '0, '0);
    send_fields(31, '0, '0, '0);
    send_fields(31, FullMask, '0, '0);
    send_fields(30, 32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_0001);

    // Sizes past the widest board behave as the widest board.
    write_board('1);
    send_fields(32, '0, '0, '0);
    send_fields(31, '0, FullMask, '0);
    send_fields(31, '0, '0, 32'h0000_FFFF);

    write_board(BoardW'(1));
    send_fields(0, '0, '0, '0);
    write_board(BoardW'(4));
    send_fields(0, '0, '0, '0);
    write_board(BoardW'(3));
    send_fields(0, '0, '0, '0);

    random_phase(12, BoardW'($urandom_range(4, 8)));
    random_phase(12, BoardW'($urandom_range(5, 10)));
    random_phase(12, BoardW'($urandom_range(11, 32)));
    random_phase(12, BoardW'($urandom_range(0, 32)));
    random_phase(12, BoardW'($urandom_range(6, 9)));
    random_phase(8, BoardW'(MaxBoard));
    calm = 1'b1;
    random_phase(12, BoardW'($urandom_range(4, 9)));

    drain();
    repeat (20) @(negedge clk_i);
    tally.close_out();
    if (tally.errors == 0) begin
      $display("tb_n_queens_solution_counter_unit: done, clean");
    end else begin
      $display("tb_n_queens_solution_counter_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_n_queens_solution_counter_unit: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/nq_pkg.sv
design/nq_if.sv
design/nq_step.sv
design/n_queens_solution_counter_unit.sv
sim/tb_n_queens_solution_counter_unit.sv
